// ----- src/icmp_echo_request_generator_assert.svh -----
// assertion macros for the echo request generator
`ifndef ICMP_ECHO_REQUEST_GENERATOR_ASSERT_SVH
`define ICMP_ECHO_REQUEST_GENERATOR_ASSERT_SVH

// antecedent and consequent in the same cycle
`define IERG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define IERG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ierg_pkg.sv -----
// shared types and constants of the echo request generator
`default_nettype none

package ierg_pkg;

    localparam int MaxPacketBytes = 64;
    localparam int MinPacketBytes = 24;
    localparam int LenWidth       = 7;
    localparam int IdWidth        = 16;
    localparam int SeqWidth       = 16;
    localparam int SecsWidth      = 63;
    localparam int UsecsWidth     = 20;
    localparam int CfgIndexWidth  = 2;
    localparam int CfgDataWidth   = 16;

    localparam logic [CfgIndexWidth-1:0] CfgPacketLength = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CfgIdentifier   = 2'd1;

    localparam logic [LenWidth-1:0] ResetPacketLength = 7'd64;
    localparam logic [IdWidth-1:0]  ResetIdentifier   = 16'h002A;

    typedef struct packed {
        logic load;
        logic sum_step;
        logic sum_done;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic sum_last;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

// ----- src/ierg_ctrl.sv -----
// controller state machine: checksum pass then byte emission
`default_nettype none

module ierg_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire ierg_pkg::t_status i_status,
    output ierg_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import ierg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start && !r_busy) begin
                    cmd.load = 1'b1;
                    n_state  = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (i_status.sum_last) begin
                    cmd.sum_done = 1'b1;
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit_step = 1'b1;
                if (i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ----- src/ierg_datapath.sv -----
// datapath: config registers, request capture, checksum accumulator, byte output
`default_nettype none
`include "icmp_echo_request_generator_assert.svh"

module ierg_datapath #(
    parameter int MAX_PACKET_BYTES = ierg_pkg::MaxPacketBytes
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    input  wire [ierg_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  wire [ierg_pkg::CfgDataWidth-1:0]     i_cfg_data,
    input  wire [ierg_pkg::SeqWidth-1:0]         i_sequence_number,
    input  wire [ierg_pkg::SecsWidth-1:0]        i_stamp_seconds,
    input  wire [ierg_pkg::UsecsWidth-1:0]       i_stamp_microseconds,
    input  wire ierg_pkg::t_cmd                  i_cmd,
    output ierg_pkg::t_status                    o_status,
    output logic                                 o_valid,
    output logic [7:0]                           o_packet_byte,
    output logic                                 o_final_byte
);
    import ierg_pkg::*;

    localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MAX_PACKET_BYTES);
    localparam logic [LenWidth-1:0] MinLen = LenWidth'(MinPacketBytes);
    localparam logic [LenWidth-1:0] PatternStart = 7'd24;

    logic [LenWidth-1:0]   r_cfg_len;
    logic [IdWidth-1:0]    r_ident;
    logic [LenWidth-1:0]   r_len;
    logic [SeqWidth-1:0]   r_seq;
    logic [SecsWidth-1:0]  r_secs;
    logic [UsecsWidth-1:0] r_usecs;
    logic [LenWidth-1:0]   r_idx;
    logic [15:0]           r_acc;
    logic                  r_valid;
    logic [7:0]            r_byte;
    logic                  r_final;

    logic [LenWidth-1:0]   eff_len;
    logic [LenWidth-1:0]   idx_lo;
    logic [7:0]            hi_byte;
    logic [7:0]            lo_byte;
    logic [15:0]           word;
    logic [16:0]           sum17;
    logic [15:0]           n_acc;
    logic [15:0]           ck;
    logic [7:0]            emit_byte;
    logic [LenWidth:0]     idx_plus2;

    function automatic logic [7:0] f_byte(
        input logic [LenWidth-1:0] idx,
        input logic [15:0]         csum,
        input logic [15:0]         ident,
        input logic [15:0]         seq,
        input logic [63:0]         secs,
        input logic [63:0]         usecs
    );
        logic [7:0] b;
        b = 8'h00;
        case (idx) inside
            7'd0:        b = 8'h08;
            7'd1:        b = 8'h00;
            7'd2:        b = csum[15:8];
            7'd3:        b = csum[7:0];
            7'd4:        b = ident[15:8];
            7'd5:        b = ident[7:0];
            7'd6:        b = seq[15:8];
            7'd7:        b = seq[7:0];
            [7'd8:7'd15]:  b = secs[{idx[2:0], 3'b000} +: 8];
            [7'd16:7'd23]: b = usecs[{idx[2:0], 3'b000} +: 8];
            default:     b = {1'b0, LenWidth'(idx - PatternStart)};
        endcase
        return b;
    endfunction

    always_comb begin
        eff_len = r_cfg_len;
        if (r_cfg_len < MinLen) begin
            eff_len = MinLen;
        end else if (r_cfg_len > MaxLen) begin
            eff_len = MaxLen;
        end
    end

    assign idx_lo  = r_idx | 7'd1;
    assign hi_byte = f_byte(r_idx, 16'h0000, r_ident, r_seq, {1'b0, r_secs},
                            {44'b0, r_usecs});
    assign lo_byte = (idx_lo < r_len) ?
                     f_byte(idx_lo, 16'h0000, r_ident, r_seq, {1'b0, r_secs},
                            {44'b0, r_usecs}) : 8'h00;
    assign word    = {hi_byte, lo_byte};
    assign sum17   = {1'b0, r_acc} + {1'b0, word};
    assign n_acc   = sum17[15:0] + {15'b0, sum17[16]};
    assign ck      = ~r_acc;

    assign emit_byte = f_byte(r_idx, ck, r_ident, r_seq, {1'b0, r_secs},
                              {44'b0, r_usecs});

    assign idx_plus2          = {1'b0, r_idx} + 8'd2;
    assign o_status.sum_last  = (idx_plus2 >= {1'b0, r_len});
    assign o_status.emit_last = (LenWidth'(r_idx + 7'd1) == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= ResetPacketLength;
            r_ident   <= ResetIdentifier;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgPacketLength: r_cfg_len <= i_cfg_data[LenWidth-1:0];
                    CfgIdentifier:   r_ident   <= i_cfg_data;
                    default:         ;
                endcase
            end
            r_valid <= i_cmd.emit_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= eff_len;
            r_seq   <= i_sequence_number;
            r_secs  <= i_stamp_seconds;
            r_usecs <= i_stamp_microseconds;
            r_idx   <= '0;
            r_acc   <= '0;
        end else if (i_cmd.sum_step) begin
            r_acc <= n_acc;
            r_idx <= i_cmd.sum_done ? '0 : LenWidth'(idx_plus2);
        end else if (i_cmd.emit_step) begin
            r_idx <= LenWidth'(r_idx + 7'd1);
        end
        if (i_cmd.emit_step) begin
            r_byte  <= emit_byte;
            r_final <= o_status.emit_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_packet_byte = r_byte;
    assign o_final_byte  = r_final;

    `IERG_ASSERT_SAME(a_emit_in_range, i_cmd.emit_step, r_idx < r_len, "emit index past length")
    `IERG_ASSERT_NEXT(a_final_then_quiet, r_valid && r_final, !r_valid, "request after final")
    `IERG_ASSERT_NEXT(a_sum_silent, i_cmd.sum_step, !r_valid, "request during checksum pass")

endmodule

`default_nettype wire

// ----- src/icmp_echo_request_generator.sv -----
// top level of the icmp echo request generator
// channel   direction  handshake                   payload
// command   in         i_start && !o_busy          sequence number, seconds, microseconds
// config    in         i_cfg_valid && o_cfg_ready  i_cfg_index, i_cfg_data
// result    out        o_valid, cannot stall       o_packet_byte, o_final_byte
// an accepted command runs a checksum pass, one 16-bit word a cycle,
// then emission, one packet byte a cycle, over the clamped packet length
// config is always ready; reset restores length 64 and identifier 42, no clearing pass
// results cannot be stalled: each byte is shown for exactly one cycle
`default_nettype none

module icmp_echo_request_generator #(
    parameter int MAX_PACKET_BYTES = ierg_pkg::MaxPacketBytes
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    output logic                              o_busy,
    input  wire [ierg_pkg::SeqWidth-1:0]      i_sequence_number,
    input  wire [ierg_pkg::SecsWidth-1:0]     i_stamp_seconds,
    input  wire [ierg_pkg::UsecsWidth-1:0]    i_stamp_microseconds,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [ierg_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire [ierg_pkg::CfgDataWidth-1:0]  i_cfg_data,
    output logic                              o_valid,
    output logic [7:0]                        o_packet_byte,
    output logic                              o_final_byte
);
    import ierg_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ierg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    ierg_datapath #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_sequence_number    (i_sequence_number),
        .i_stamp_seconds      (i_stamp_seconds),
        .i_stamp_microseconds (i_stamp_microseconds),
        .i_cmd                (cmd),
        .o_status             (status),
        .o_valid              (o_valid),
        .o_packet_byte        (o_packet_byte),
        .o_final_byte         (o_final_byte)
    );

endmodule

`default_nettype wire
